[hw/rtl/gss_pkg.sv]
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types, constants and codes of the gear shift sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package gss_pkg;

  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned GEAR_W   = 3;
  localparam int unsigned CUT_W    = 8;
  localparam int unsigned NUM_LVL  = 5;
  localparam int unsigned CFG_IDX_W = 3;

  // match window around each configured level
  localparam int unsigned WINDOW = 150;

  // timeout defaults, in ticks
  localparam int unsigned UP_CUT_DELAY_DEF           = 20;
  localparam int unsigned UP_FINISH_TIMEOUT_DEF      = 100;
  localparam int unsigned DOWN_ACTUATOR_DELAY_DEF    = 20;
  localparam int unsigned DOWN_FINISH_TIMEOUT_DEF    = 100;
  localparam int unsigned OPEN_UP_CUT_DELAY_DEF      = 20;
  localparam int unsigned OPEN_DOWN_CLUTCH_DELAY_DEF = 100;

  // level reset values
  localparam logic [LEVEL_W-1:0] NEUTRAL_LEVEL_RST = 12'd500;
  localparam logic [LEVEL_W-1:0] FIRST_LEVEL_RST   = 12'd0;
  localparam logic [LEVEL_W-1:0] SECOND_LEVEL_RST  = 12'd1470;
  localparam logic [LEVEL_W-1:0] THIRD_LEVEL_RST   = 12'd1870;
  localparam logic [LEVEL_W-1:0] FOURTH_LEVEL_RST  = 12'd2300;

  // cut demand values
  localparam logic [CUT_W-1:0] CUT_NONE = 8'd127;
  localparam logic [CUT_W-1:0] CUT_FULL = 8'd255;
  localparam logic [CUT_W-1:0] CUT_ZERO = 8'd0;

  // gear codes
  localparam logic [GEAR_W-1:0] GEAR_NEUTRAL = 3'd0;
  localparam logic [GEAR_W-1:0] GEAR_FIRST   = 3'd1;
  localparam logic [GEAR_W-1:0] GEAR_FOURTH  = 3'd4;
  localparam logic [GEAR_W-1:0] GEAR_UNKNOWN = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOURTH  = 3'd4;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_UP   = 2'd1,
    MODE_DOWN = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    PH_IDLE           = 4'd0,
    PH_START_UP       = 4'd1,
    PH_UP_NEUTRAL     = 4'd2,
    PH_UP_CUT         = 4'd3,
    PH_UP_FINISH      = 4'd4,
    PH_START_DOWN     = 4'd5,
    PH_DOWN_NEUTRAL   = 4'd6,
    PH_DOWN_CLUTCH    = 4'd7,
    PH_DOWN_FINISH    = 4'd8,
    PH_OL_UP_CUT      = 4'd9,
    PH_OL_UP_FINISH   = 4'd10,
    PH_OL_DOWN_CLUTCH = 4'd11,
    PH_OL_DOWN_FINISH = 4'd12
  } phase_t;

  typedef logic [NUM_LVL-1:0][LEVEL_W-1:0] level_arr_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [LEVEL_W-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic [GEAR_W-1:0] gear;
    logic              shift_up_pin;
    logic              shift_down_pin;
    logic              cut_pin;
    logic              clutch_act;
    logic [CUT_W-1:0]  cut_level;
    logic              idle;
    logic [3:0]        phase;
    logic [TICK_W-1:0] up_duration;
    logic [TICK_W-1:0] down_duration;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [LEVEL_W-1:0]   data;
  } cfg_item_t;

  // sequencer state after one step
  typedef struct packed {
    phase_t            phase;
    logic              up_pin;
    logic              down_pin;
    logic              cut_pin;
    logic              clutch_act;
    logic [CUT_W-1:0]  cut_value;
    logic [TICK_W-1:0] up_time;
    logic [TICK_W-1:0] down_time;
  } seq_state_t;

endpackage

`default_nettype wire

[hw/rtl/gss_chan_if.sv]
// ----------------------------------------------------------------------------
// gss_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface gss_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/gss_gear_decode.sv]
// ----------------------------------------------------------------------------
// gss_gear_decode
// Matches a position sample against the five gear levels, first match wins.
// ----------------------------------------------------------------------------
`default_nettype none

module gss_gear_decode (
  input  wire gss_pkg::level_arr_t              levels,
  input  wire logic [gss_pkg::LEVEL_W-1:0]      sample,
  output logic      [gss_pkg::GEAR_W-1:0]       gear
);
  import gss_pkg::*;

  localparam int unsigned EXT_W = LEVEL_W + 2;

  logic signed [EXT_W-1:0] samp_s;
  logic [NUM_LVL-1:0]      hit;

  assign samp_s = signed'({2'b00, sample});

  always_comb begin
    for (int g = 0; g < NUM_LVL; g++) begin
      // low bound may go negative for levels near zero
      hit[g] = (samp_s >= signed'({2'b00, levels[g]}) - signed'(EXT_W'(WINDOW))) &&
               (samp_s <= signed'({2'b00, levels[g]}) + signed'(EXT_W'(WINDOW)));
    end
  end

  always_comb begin
    gear = GEAR_UNKNOWN;
    for (int g = NUM_LVL - 1; g >= 0; g--) begin
      if (hit[g]) begin
        gear = GEAR_W'(g);
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/gss_seq.sv]
// ----------------------------------------------------------------------------
// gss_seq
// Shift sequencer: tick counter, phase register, timestamps and pins.
// ----------------------------------------------------------------------------
`default_nettype none

module gss_seq #(
  parameter int unsigned UP_CUT_DELAY           = gss_pkg::UP_CUT_DELAY_DEF,
  parameter int unsigned UP_FINISH_TIMEOUT      = gss_pkg::UP_FINISH_TIMEOUT_DEF,
  parameter int unsigned DOWN_ACTUATOR_DELAY    = gss_pkg::DOWN_ACTUATOR_DELAY_DEF,
  parameter int unsigned DOWN_FINISH_TIMEOUT    = gss_pkg::DOWN_FINISH_TIMEOUT_DEF,
  parameter int unsigned OPEN_UP_CUT_DELAY      = gss_pkg::OPEN_UP_CUT_DELAY_DEF,
  parameter int unsigned OPEN_DOWN_CLUTCH_DELAY = gss_pkg::OPEN_DOWN_CLUTCH_DELAY_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step_en,
  input  wire logic [1:0]                     mode,
  input  wire logic [gss_pkg::GEAR_W-1:0]     gear,
  output gss_pkg::seq_state_t                 state_nxt
);
  import gss_pkg::*;

  phase_t             phase_r, phase_nxt, ph_eff;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [TICK_W-1:0]  stamp_r, stamp_nxt;
  logic [TICK_W-1:0]  begin_r, begin_nxt;
  logic [GEAR_W-1:0]  bgear_r, bgear_nxt;
  logic [3:0]         pins_r, pins_nxt;     // {clutch, cut, down, up}
  logic [CUT_W-1:0]   cut_r, cut_nxt;
  logic [TICK_W-1:0]  up_time_r, up_time_nxt;
  logic [TICK_W-1:0]  dn_time_r, dn_time_nxt;
  logic [TICK_W-1:0]  elapsed;
  logic [TICK_W-1:0]  shift_len;
  logic               gear_up_done, gear_dn_done, adv;

  assign tick_nxt  = tick_r + TICK_W'(1);
  assign elapsed   = tick_nxt - stamp_r;
  assign shift_len = tick_nxt - begin_r;

  assign gear_up_done = {1'b0, gear} == ({1'b0, bgear_r} + (GEAR_W + 1)'(1));
  assign gear_dn_done = ({1'b0, gear} + (GEAR_W + 1)'(1)) == {1'b0, bgear_r};

  // a request is only taken while idle, and its start phase runs this step
  always_comb begin
    ph_eff = phase_r;
    if (phase_r == PH_IDLE) begin
      if (mode == MODE_UP) begin
        ph_eff = PH_START_UP;
      end else if (mode == MODE_DOWN) begin
        ph_eff = PH_START_DOWN;
      end
    end
  end

  // next phase
  always_comb begin
    phase_nxt = ph_eff;
    unique case (ph_eff)
      PH_IDLE: phase_nxt = PH_IDLE;
      PH_START_UP: begin
        if (gear == GEAR_UNKNOWN)       phase_nxt = PH_OL_UP_CUT;
        else if (gear == GEAR_FOURTH)   phase_nxt = PH_IDLE;
        else if (gear == GEAR_NEUTRAL)  phase_nxt = PH_UP_NEUTRAL;
        else                            phase_nxt = PH_UP_CUT;
      end
      PH_UP_NEUTRAL: begin
        if (gear == GEAR_FIRST || elapsed >= TICK_W'(UP_FINISH_TIMEOUT)) begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_UP_CUT: begin
        if (elapsed >= TICK_W'(UP_CUT_DELAY)) phase_nxt = PH_UP_FINISH;
      end
      PH_OL_UP_CUT: begin
        if (elapsed >= TICK_W'(OPEN_UP_CUT_DELAY)) phase_nxt = PH_OL_UP_FINISH;
      end
      PH_UP_FINISH: begin
        if (gear_up_done || elapsed >= TICK_W'(UP_FINISH_TIMEOUT)) phase_nxt = PH_IDLE;
      end
      PH_OL_UP_FINISH: begin
        if (elapsed >= TICK_W'(UP_FINISH_TIMEOUT)) phase_nxt = PH_IDLE;
      end
      PH_START_DOWN: begin
        if (gear == GEAR_UNKNOWN)       phase_nxt = PH_OL_DOWN_CLUTCH;
        else if (gear == GEAR_NEUTRAL)  phase_nxt = PH_IDLE;
        else if (gear == GEAR_FIRST)    phase_nxt = PH_DOWN_NEUTRAL;
        else                            phase_nxt = PH_DOWN_CLUTCH;
      end
      PH_DOWN_NEUTRAL: begin
        if (elapsed >= TICK_W'(DOWN_ACTUATOR_DELAY)) phase_nxt = PH_DOWN_FINISH;
      end
      PH_DOWN_CLUTCH: begin
        if (elapsed >= TICK_W'(DOWN_ACTUATOR_DELAY)) phase_nxt = PH_DOWN_FINISH;
      end
      PH_OL_DOWN_CLUTCH: begin
        if (elapsed >= TICK_W'(DOWN_ACTUATOR_DELAY)) phase_nxt = PH_OL_DOWN_FINISH;
      end
      PH_DOWN_FINISH: begin
        if (gear_dn_done || elapsed >= TICK_W'(DOWN_FINISH_TIMEOUT)) phase_nxt = PH_IDLE;
      end
      PH_OL_DOWN_FINISH: begin
        if (elapsed >= TICK_W'(OPEN_DOWN_CLUTCH_DELAY)) phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // every wait phase acts exactly when it leaves
  assign adv = (phase_nxt != ph_eff);

  // datapath updates
  always_comb begin
    stamp_nxt   = stamp_r;
    begin_nxt   = begin_r;
    bgear_nxt   = bgear_r;
    pins_nxt    = pins_r;
    cut_nxt     = cut_r;
    up_time_nxt = up_time_r;
    dn_time_nxt = dn_time_r;
    unique case (ph_eff)
      PH_START_UP: begin
        bgear_nxt = gear;
        begin_nxt = tick_nxt;
        if (gear != GEAR_FOURTH) begin
          pins_nxt[0] = 1'b1;
          stamp_nxt   = tick_nxt;
        end
      end
      PH_UP_NEUTRAL: begin
        if (adv) begin
          pins_nxt[0] = 1'b0;
          stamp_nxt   = tick_nxt;
        end
      end
      PH_UP_CUT, PH_OL_UP_CUT: begin
        if (adv) begin
          pins_nxt[2] = 1'b1;
          cut_nxt     = CUT_FULL;
          stamp_nxt   = tick_nxt;
        end
      end
      PH_UP_FINISH, PH_OL_UP_FINISH: begin
        if (adv) begin
          pins_nxt[2] = 1'b0;
          pins_nxt[0] = 1'b0;
          cut_nxt     = CUT_NONE;
          stamp_nxt   = tick_nxt;
          up_time_nxt = shift_len;
        end
      end
      PH_START_DOWN: begin
        begin_nxt = tick_nxt;
        bgear_nxt = gear;
        if (gear != GEAR_NEUTRAL) begin
          pins_nxt[1] = 1'b0;
          stamp_nxt   = tick_nxt;
        end
      end
      PH_DOWN_NEUTRAL: begin
        if (adv) begin
          pins_nxt[1] = 1'b1;
          stamp_nxt   = tick_nxt;
          dn_time_nxt = shift_len;
        end
      end
      PH_DOWN_CLUTCH, PH_OL_DOWN_CLUTCH: begin
        if (adv) begin
          pins_nxt[3] = 1'b1;
          stamp_nxt   = tick_nxt;
          cut_nxt     = CUT_ZERO;
        end
      end
      PH_DOWN_FINISH, PH_OL_DOWN_FINISH: begin
        if (adv) begin
          pins_nxt[3] = 1'b0;
          pins_nxt[1] = 1'b0;
          cut_nxt     = CUT_NONE;
          stamp_nxt   = tick_nxt;
          dn_time_nxt = shift_len;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= '0;
      stamp_r   <= '0;
      begin_r   <= '0;
      bgear_r   <= '0;
      pins_r    <= '0;
      cut_r     <= CUT_NONE;
      up_time_r <= '0;
      dn_time_r <= '0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      stamp_r   <= stamp_nxt;
      begin_r   <= begin_nxt;
      bgear_r   <= bgear_nxt;
      pins_r    <= pins_nxt;
      cut_r     <= cut_nxt;
      up_time_r <= up_time_nxt;
      dn_time_r <= dn_time_nxt;
    end
  end

  always_comb begin
    state_nxt.phase      = phase_nxt;
    state_nxt.up_pin     = pins_nxt[0];
    state_nxt.down_pin   = pins_nxt[1];
    state_nxt.cut_pin    = pins_nxt[2];
    state_nxt.clutch_act = pins_nxt[3];
    state_nxt.cut_value  = cut_nxt;
    state_nxt.up_time    = up_time_nxt;
    state_nxt.down_time  = dn_time_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/gear_shift_sequencer.sv]
// ----------------------------------------------------------------------------
// gear_shift_sequencer
// Gear decode and shift sequencing, one tick beat in, one status beat out.
// ----------------------------------------------------------------------------
// Each input beat is one millisecond tick carrying a shift request and a
// gear position sample. The beat is registered, then the gear is decoded
// against the five level registers, the sequencer takes one step and the
// resulting pins, cut level, phase and durations land in the output
// register. One beat per clock is sustained while the consumer is ready. The
// output register decouples the sides, so a stalled consumer only holds the
// input stage once both registers are full. Level registers are written
// through the cfg channel (always ready) and should only be changed while no
// beat is in flight.
`default_nettype none

module gear_shift_sequencer #(
  parameter int unsigned UP_CUT_DELAY           = gss_pkg::UP_CUT_DELAY_DEF,
  parameter int unsigned UP_FINISH_TIMEOUT      = gss_pkg::UP_FINISH_TIMEOUT_DEF,
  parameter int unsigned DOWN_ACTUATOR_DELAY    = gss_pkg::DOWN_ACTUATOR_DELAY_DEF,
  parameter int unsigned DOWN_FINISH_TIMEOUT    = gss_pkg::DOWN_FINISH_TIMEOUT_DEF,
  parameter int unsigned OPEN_UP_CUT_DELAY      = gss_pkg::OPEN_UP_CUT_DELAY_DEF,
  parameter int unsigned OPEN_DOWN_CLUTCH_DELAY = gss_pkg::OPEN_DOWN_CLUTCH_DELAY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gss_chan_if.sink   in_bus,
  gss_chan_if.source out_bus,
  gss_chan_if.sink   cfg_bus
);
  import gss_pkg::*;

  level_arr_t         levels_r;
  in_item_t           in_item_r;
  logic               in_vld_r;
  out_item_t          out_item_r, out_item_nxt;
  logic               out_vld_r;
  logic               step, in_take;
  logic [GEAR_W-1:0]  gear;
  seq_state_t         st_nxt;
  cfg_item_t          cfg_beat;

  assign step    = in_vld_r && (!out_vld_r || out_bus.ready);
  assign in_take = in_bus.valid && in_bus.ready;

  assign in_bus.ready  = !in_vld_r || step;
  assign cfg_bus.ready = 1'b1;
  assign cfg_beat      = cfg_bus.data;

  // level registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r[REG_NEUTRAL] <= NEUTRAL_LEVEL_RST;
      levels_r[REG_FIRST]   <= FIRST_LEVEL_RST;
      levels_r[REG_SECOND]  <= SECOND_LEVEL_RST;
      levels_r[REG_THIRD]   <= THIRD_LEVEL_RST;
      levels_r[REG_FOURTH]  <= FOURTH_LEVEL_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_beat.index)
        REG_NEUTRAL: levels_r[REG_NEUTRAL] <= cfg_beat.data;
        REG_FIRST:   levels_r[REG_FIRST]   <= cfg_beat.data;
        REG_SECOND:  levels_r[REG_SECOND]  <= cfg_beat.data;
        REG_THIRD:   levels_r[REG_THIRD]   <= cfg_beat.data;
        REG_FOURTH:  levels_r[REG_FOURTH]  <= cfg_beat.data;
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_bus.data;
    end
  end

  gss_gear_decode u_decode (
    .levels (levels_r),
    .sample (in_item_r.adc_sample),
    .gear   (gear)
  );

  gss_seq #(
    .UP_CUT_DELAY           (UP_CUT_DELAY),
    .UP_FINISH_TIMEOUT      (UP_FINISH_TIMEOUT),
    .DOWN_ACTUATOR_DELAY    (DOWN_ACTUATOR_DELAY),
    .DOWN_FINISH_TIMEOUT    (DOWN_FINISH_TIMEOUT),
    .OPEN_UP_CUT_DELAY      (OPEN_UP_CUT_DELAY),
    .OPEN_DOWN_CLUTCH_DELAY (OPEN_DOWN_CLUTCH_DELAY)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step),
    .mode      (in_item_r.mode),
    .gear      (gear),
    .state_nxt (st_nxt)
  );

  always_comb begin
    out_item_nxt.gear           = gear;
    out_item_nxt.shift_up_pin   = st_nxt.up_pin;
    out_item_nxt.shift_down_pin = st_nxt.down_pin;
    out_item_nxt.cut_pin        = st_nxt.cut_pin;
    out_item_nxt.clutch_act     = st_nxt.clutch_act;
    out_item_nxt.cut_level      = st_nxt.cut_value;
    out_item_nxt.idle           = (st_nxt.phase == PH_IDLE);
    out_item_nxt.phase          = st_nxt.phase;
    out_item_nxt.up_duration    = st_nxt.up_time;
    out_item_nxt.down_duration  = st_nxt.down_time;
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_bus.valid = out_vld_r;
  assign out_bus.data  = out_item_r;

  // cut pin is only up during an upshift finish, where full cut is demanded
  a_cut_pin_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_item_r.cut_pin |-> out_item_r.cut_level == CUT_FULL)
    else $error("cut pin high without full cut demand");

  // a full input stage with a free output stage always produces a beat
  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !out_vld_r |=> out_vld_r)
    else $error("pending tick did not reach output register");

  // a blocked output must hold the pending input beat
  a_stall_holds_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_bus.ready |=> in_vld_r && $stable(in_item_r))
    else $error("input beat lost while output stalled");

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gear shift sequencer.
// ----------------------------------------------------------------------------
// Tick beats go in over the input channel. A local model of the decoder and
// shift sequencer predicts each status beat, and a monitor compares every
// output beat field by field. Directed ticks hit the decode windows and the
// request corner cases. Random shift sequences then run through all paths
// under several level settings, with random gaps on the sender and random
// stalls on the receiver.
// ----------------------------------------------------------------------------

module tb_top;
  import gss_pkg::*;

  localparam int WIN = int'(WINDOW);
  localparam logic [CFG_IDX_W-1:0] REG_BEYOND_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BEYOND_HI = 3'd7;

  logic clk;
  logic rst_n;

  gss_chan_if #(.payload_t(in_item_t))  in_if  ();
  gss_chan_if #(.payload_t(out_item_t)) out_if ();
  gss_chan_if #(.payload_t(cfg_item_t)) cfg_if ();

  gear_shift_sequencer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if.sink),
    .out_bus (out_if.source),
    .cfg_bus (cfg_if.sink)
  );

  // model state
  logic [LEVEL_W-1:0] lvl_cfg [NUM_LVL];
  phase_t             seq_phase;
  logic [TICK_W-1:0]  tick_cnt;
  logic [TICK_W-1:0]  stamp;
  logic [TICK_W-1:0]  shift_t0;
  logic [GEAR_W-1:0]  gear0;
  logic               up_pin, down_pin, cut_pin, clutch_act;
  logic [CUT_W-1:0]   cut_val;
  logic [TICK_W-1:0]  up_dur;
  logic [TICK_W-1:0]  down_dur;

  out_item_t status_q [$];
  out_item_t got_beat, want_beat;

  int  err_cnt       = 0;
  int  ticks_sent    = 0;
  int  beats_checked = 0;
  int  shifts_begun  = 0;
  int  cfg_writes    = 0;
  bit  calm          = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // model
  // --------------------------------------------------------------------------
  function automatic logic [GEAR_W-1:0] decode_gear_of(logic [LEVEL_W-1:0] sample);
    int s;
    int lv;
    int g;
    s = int'(sample);
    for (g = 0; g < NUM_LVL; g++) begin
      lv = int'(lvl_cfg[g]);
      if (s >= lv - WIN && s <= lv + WIN) return g[GEAR_W-1:0];
    end
    return GEAR_UNKNOWN;
  endfunction

  function automatic bit expired(int unsigned limit);
    logic [TICK_W-1:0] d;
    d = tick_cnt - stamp;
    return d >= limit;
  endfunction

  function automatic out_item_t advance_tick(logic [1:0] mode, logic [LEVEL_W-1:0] sample);
    logic [GEAR_W-1:0] g;
    out_item_t         r;
    tick_cnt = tick_cnt + 1;
    g = decode_gear_of(sample);
    if (seq_phase == PH_IDLE) begin
      if (mode == MODE_UP) seq_phase = PH_START_UP;
      else if (mode == MODE_DOWN) seq_phase = PH_START_DOWN;
    end
    case (seq_phase)
      PH_IDLE: begin
      end
      PH_START_UP: begin
        gear0 = g;
        shift_t0 = tick_cnt;
        if (g == GEAR_UNKNOWN) begin
          up_pin = 1'b1;
          stamp = tick_cnt;
          seq_phase = PH_OL_UP_CUT;
        end else if (g == GEAR_FOURTH) begin
          seq_phase = PH_IDLE;
        end else begin
          up_pin = 1'b1;
          stamp = tick_cnt;
          seq_phase = (g == GEAR_NEUTRAL) ? PH_UP_NEUTRAL : PH_UP_CUT;
        end
      end
      PH_UP_NEUTRAL: begin
        if (g == GEAR_FIRST || expired(UP_FINISH_TIMEOUT_DEF)) begin
          up_pin = 1'b0;
          stamp = tick_cnt;
          seq_phase = PH_IDLE;
        end
      end
      PH_UP_CUT, PH_OL_UP_CUT: begin
        if (expired(seq_phase == PH_UP_CUT ? UP_CUT_DELAY_DEF : OPEN_UP_CUT_DELAY_DEF)) begin
          cut_pin = 1'b1;
          cut_val = CUT_FULL;
          stamp = tick_cnt;
          seq_phase = (seq_phase == PH_UP_CUT) ? PH_UP_FINISH : PH_OL_UP_FINISH;
        end
      end
      PH_UP_FINISH, PH_OL_UP_FINISH: begin
        if ((seq_phase == PH_UP_FINISH && int'(g) == int'(gear0) + 1) ||
            expired(UP_FINISH_TIMEOUT_DEF)) begin
          cut_pin = 1'b0;
          up_pin = 1'b0;
          cut_val = CUT_NONE;
          stamp = tick_cnt;
          up_dur = stamp - shift_t0;
          seq_phase = PH_IDLE;
        end
      end
      PH_START_DOWN: begin
        shift_t0 = tick_cnt;
        gear0 = g;
        if (g == GEAR_UNKNOWN) begin
          down_pin = 1'b0;
          stamp = tick_cnt;
          seq_phase = PH_OL_DOWN_CLUTCH;
        end else if (g == GEAR_NEUTRAL) begin
          seq_phase = PH_IDLE;
        end else begin
          down_pin = 1'b0;
          stamp = tick_cnt;
          seq_phase = (g == GEAR_FIRST) ? PH_DOWN_NEUTRAL : PH_DOWN_CLUTCH;
        end
      end
      PH_DOWN_NEUTRAL: begin
        // the only path that raises the down pin
        if (expired(DOWN_ACTUATOR_DELAY_DEF)) begin
          down_pin = 1'b1;
          stamp = tick_cnt;
          down_dur = stamp - shift_t0;
          seq_phase = PH_DOWN_FINISH;
        end
      end
      PH_DOWN_CLUTCH, PH_OL_DOWN_CLUTCH: begin
        if (expired(DOWN_ACTUATOR_DELAY_DEF)) begin
          clutch_act = 1'b1;
          stamp = tick_cnt;
          cut_val = CUT_ZERO;
          seq_phase = (seq_phase == PH_DOWN_CLUTCH) ? PH_DOWN_FINISH : PH_OL_DOWN_FINISH;
        end
      end
      PH_DOWN_FINISH, PH_OL_DOWN_FINISH: begin
        if ((seq_phase == PH_DOWN_FINISH && int'(g) + 1 == int'(gear0)) ||
            expired(seq_phase == PH_DOWN_FINISH ? DOWN_FINISH_TIMEOUT_DEF
                                                : OPEN_DOWN_CLUTCH_DELAY_DEF)) begin
          clutch_act = 1'b0;
          down_pin = 1'b0;
          cut_val = CUT_NONE;
          stamp = tick_cnt;
          down_dur = stamp - shift_t0;
          seq_phase = PH_IDLE;
        end
      end
      default: seq_phase = PH_IDLE;
    endcase
    r.gear           = g;
    r.shift_up_pin   = up_pin;
    r.shift_down_pin = down_pin;
    r.cut_pin        = cut_pin;
    r.clutch_act     = clutch_act;
    r.cut_level      = cut_val;
    r.idle           = (seq_phase == PH_IDLE);
    r.phase          = seq_phase;
    r.up_duration    = up_dur;
    r.down_duration  = down_dur;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  task automatic send_tick(logic [1:0] mode, logic [LEVEL_W-1:0] sample);
    int        gap;
    in_item_t  beat;
    out_item_t exp_beat;
    gap = calm ? 0 : $urandom_range(0, 12);
    beat.mode = mode;
    beat.adc_sample = sample;
    @(negedge clk);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= beat;
    do @(posedge clk); while (!in_if.ready);
    exp_beat = advance_tick(mode, sample);
    status_q.push_back(exp_beat);
    ticks_sent++;
  endtask

  // drop valid and let every outstanding status beat come back
  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_level(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] val);
    cfg_item_t beat;
    beat.index = idx;
    beat.data  = val;
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= beat;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx < NUM_LVL) lvl_cfg[idx] = val;
    cfg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_levels(logic [LEVEL_W-1:0] n_lv, logic [LEVEL_W-1:0] l1,
                             logic [LEVEL_W-1:0] l2, logic [LEVEL_W-1:0] l3,
                             logic [LEVEL_W-1:0] l4);
    wait_drained();
    write_level(REG_NEUTRAL, n_lv);
    write_level(REG_FIRST, l1);
    write_level(REG_SECOND, l2);
    write_level(REG_THIRD, l3);
    write_level(REG_FOURTH, l4);
  endtask

  // out_bus ready with a fresh random stall before each beat
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
    end
  end

  // --------------------------------------------------------------------------
  // monitor
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      got_beat = out_if.data;
      if (status_q.size() == 0) begin
        $error("status beat with nothing expected");
        err_cnt++;
      end else begin
        want_beat = status_q.pop_front();
        beats_checked++;
        check_field("gear", 32'(want_beat.gear), 32'(got_beat.gear));
        check_field("shift_up_pin", 32'(want_beat.shift_up_pin),
                    32'(got_beat.shift_up_pin));
        check_field("shift_down_pin", 32'(want_beat.shift_down_pin),
                    32'(got_beat.shift_down_pin));
        check_field("cut_pin", 32'(want_beat.cut_pin), 32'(got_beat.cut_pin));
        check_field("clutch_act", 32'(want_beat.clutch_act), 32'(got_beat.clutch_act));
        check_field("cut_level", 32'(want_beat.cut_level), 32'(got_beat.cut_level));
        check_field("idle", 32'(want_beat.idle), 32'(got_beat.idle));
        check_field("phase", 32'(want_beat.phase), 32'(got_beat.phase));
        check_field("up_duration", want_beat.up_duration, got_beat.up_duration);
        check_field("down_duration", want_beat.down_duration, got_beat.down_duration);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // random sample that decodes to gear g under the current levels, if any does
  function automatic logic [LEVEL_W-1:0] pick_sample(logic [GEAR_W-1:0] g);
    int               v;
    int               tries;
    logic [LEVEL_W-1:0] s;
    s = LEVEL_W'($urandom_range(0, 4095));
    for (tries = 0; tries < 64; tries++) begin
      if (g >= GEAR_UNKNOWN) v = $urandom_range(0, 4095);
      else v = int'(lvl_cfg[g]) + int'($urandom_range(0, 2 * WIN)) - WIN;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      s = v[LEVEL_W-1:0];
      if (decode_gear_of(s) == g) return s;
    end
    return s;
  endfunction

  // mostly no request, now and then a stray one the busy sequencer must ignore
  function automatic logic [1:0] stray_mode();
    logic [1:0] m;
    m = MODE_NONE;
    if ($urandom_range(0, 9) == 0) m = 2'($urandom_range(0, 3));
    return m;
  endfunction

  task automatic run_shift();
    logic [1:0]        req;
    logic [GEAR_W-1:0] g0, tgt;
    int                hold, n;
    req = ($urandom_range(0, 1) != 0) ? MODE_UP : MODE_DOWN;
    g0 = GEAR_W'($urandom_range(0, 5));
    send_tick(req, pick_sample(g0));
    shifts_begun++;
    // long holds run into the finish timeouts
    hold = ($urandom_range(0, 7) == 0) ? $urandom_range(90, 130) : $urandom_range(0, 30);
    for (n = 0; n < hold && seq_phase != PH_IDLE; n++) send_tick(stray_mode(), pick_sample(g0));
    if (g0 == GEAR_UNKNOWN) tgt = GEAR_UNKNOWN;
    else if (req == MODE_UP) tgt = GEAR_W'(g0 + 1);
    else tgt = (g0 == GEAR_NEUTRAL) ? GEAR_NEUTRAL : GEAR_W'(g0 - 1);
    if ($urandom_range(0, 5) == 0) tgt = GEAR_W'($urandom_range(0, 5));
    n = 0;
    while (seq_phase != PH_IDLE && n < 160) begin
      send_tick(stray_mode(), pick_sample(tgt));
      n++;
    end
  endtask

  task automatic run_noise();
    int k, n;
    n = $urandom_range(1, 8);
    for (k = 0; k < n; k++) begin
      send_tick(2'($urandom_range(0, 3)), LEVEL_W'($urandom_range(0, 4095)));
    end
  endtask

  task automatic run_batch(int count);
    int goal;
    goal = ticks_sent + count;
    while (ticks_sent < goal) begin
      if ($urandom_range(0, 4) == 0) calm = ~calm;
      if ($urandom_range(0, 4) == 0) run_noise();
      else run_shift();
    end
    calm = 0;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_gear_decode();
    send_tick(MODE_NONE, 12'd0);
    send_tick(MODE_NONE, 12'd150);
    send_tick(MODE_NONE, 12'd151);
    send_tick(MODE_RSVD, 12'd349);
    send_tick(MODE_NONE, 12'd350);
    send_tick(MODE_NONE, 12'd650);
    send_tick(MODE_RSVD, 12'd651);
    send_tick(MODE_NONE, 12'd1320);
    send_tick(MODE_NONE, 12'd1620);
    send_tick(MODE_NONE, 12'd1720);
    send_tick(MODE_NONE, 12'd2020);
    send_tick(MODE_NONE, 12'd2150);
    send_tick(MODE_NONE, 12'd2450);
    send_tick(MODE_NONE, 12'd4095);
  endtask

  task automatic test_request_edges();
    send_tick(MODE_UP, 12'd2300);    // upshift in fourth: straight back to idle
    send_tick(MODE_DOWN, 12'd500);   // downshift in neutral: same
    send_tick(MODE_UP, 12'd500);     // up from neutral
    send_tick(MODE_DOWN, 12'd500);   // busy, ignored
    send_tick(MODE_NONE, 12'd0);     // first gear seen, shift done
    send_tick(MODE_DOWN, 12'd0);     // down toward neutral, left running
    send_tick(MODE_NONE, 12'd0);
  endtask

  task automatic test_random_shifts();
    run_batch(300);
    wait_drained();
    run_batch(200);
  endtask

  task automatic test_level_config();
    // alternating bit patterns with both ends of the range
    load_levels(12'hAAA, 12'h555, 12'hFFF, 12'h000, 12'd2000);
    write_level(REG_BEYOND_LO, 12'h555);
    write_level(REG_BEYOND_HI, 12'hAAA);
    run_batch(80);
    // all levels equal: neutral always wins
    load_levels(12'd2048, 12'd2048, 12'd2048, 12'd2048, 12'd2048);
    run_batch(70);
    // overlapping windows near zero
    load_levels(12'd100, 12'd200, 12'd300, 12'd400, 12'hFFF);
    write_level(CFG_IDX_W'(REG_BEYOND_LO + 1), LEVEL_W'($urandom_range(0, 4095)));
    run_batch(70);
    load_levels(NEUTRAL_LEVEL_RST, FIRST_LEVEL_RST, SECOND_LEVEL_RST,
                THIRD_LEVEL_RST, FOURTH_LEVEL_RST);
    run_batch(60);
  endtask

  initial begin
    int k;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    lvl_cfg[0] = NEUTRAL_LEVEL_RST;
    lvl_cfg[1] = FIRST_LEVEL_RST;
    lvl_cfg[2] = SECOND_LEVEL_RST;
    lvl_cfg[3] = THIRD_LEVEL_RST;
    lvl_cfg[4] = FOURTH_LEVEL_RST;
    seq_phase = PH_IDLE;
    tick_cnt = '0;
    stamp = '0;
    shift_t0 = '0;
    gear0 = GEAR_NEUTRAL;
    {up_pin, down_pin, cut_pin, clutch_act} = 4'b0;
    cut_val = CUT_NONE;
    up_dur = '0;
    down_dur = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_gear_decode();
    test_request_edges();
    test_random_shifts();
    test_level_config();

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d ticks, %0d shift requests, %0d level writes; %0d status beats checked.",
             ticks_sent, shifts_begun, cfg_writes, beats_checked);
    if (err_cnt == 0 && status_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
